// File: src/ehp_pkg.sv
// shared types, constants and the byte classifier for the extensions header parser
// no dependencies
package ehp_pkg;

  localparam int BYTE_W = 8;
  localparam int ROLE_W = 3;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [ROLE_W-1:0] role_t;

  localparam role_t ROLE_DELIM  = 3'd0;
  localparam role_t ROLE_EXT    = 3'd1;
  localparam role_t ROLE_PNAME  = 3'd2;
  localparam role_t ROLE_PVALUE = 3'd3;
  localparam role_t ROLE_IGNORE = 3'd4;

  localparam byte_t CH_SPACE  = 8'h20;
  localparam byte_t CH_TAB    = 8'h09;
  localparam byte_t CH_COMMA  = 8'h2C;
  localparam byte_t CH_SEMI   = 8'h3B;
  localparam byte_t CH_EQUAL  = 8'h3D;
  localparam byte_t CH_QUOTE  = 8'h22;
  localparam byte_t CH_BSLASH = 8'h5C;
  localparam byte_t CH_DEL    = 8'h7F;

  typedef enum logic [2:0] {
    CLS_TOKEN,
    CLS_OWS,
    CLS_COMMA,
    CLS_SEMI,
    CLS_EQUAL,
    CLS_QUOTE,
    CLS_BSLASH,
    CLS_OTHER
  } byte_cls_t;

  // one classified transaction waiting for the grammar engine
  typedef struct packed {
    byte_t     data;
    byte_cls_t cls;
    logic      has_byte;
    logic      last;
  } queue_entry_t;

  function automatic logic tok_char_ok(input byte_t c);
    logic r;
    r = 1'b0;
    if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
        (c >= 8'h61 && c <= 8'h7A)) begin
      r = 1'b1;
    end else begin
      case (c)
        8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
        8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: r = 1'b1;
        default: r = 1'b0;
      endcase
    end
    return r;
  endfunction

  function automatic byte_cls_t classify(input byte_t c);
    byte_cls_t k;
    if (tok_char_ok(c)) begin
      k = CLS_TOKEN;
    end else begin
      case (c)
        CH_SPACE, CH_TAB: k = CLS_OWS;
        CH_COMMA:         k = CLS_COMMA;
        CH_SEMI:          k = CLS_SEMI;
        CH_EQUAL:         k = CLS_EQUAL;
        CH_QUOTE:         k = CLS_QUOTE;
        CH_BSLASH:        k = CLS_BSLASH;
        default:          k = CLS_OTHER; // control bytes, DEL, high bytes, other punctuation
      endcase
    end
    return k;
  endfunction

endpackage

// File: src/ehp_in_if.sv
// input channel of the extensions header parser: valid/ready plus header byte payload
// depends on ehp_pkg
interface ehp_in_if import ehp_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t in_byte;
  logic  has_byte;
  logic  last;

  modport source (output valid, output in_byte, output has_byte, output last, input ready);
  modport sink (input valid, input in_byte, input has_byte, input last, output ready);
endinterface

// File: src/ehp_out_if.sv
// result channel of the extensions header parser: valid/ready plus tagged byte payload
// depends on ehp_pkg
interface ehp_out_if import ehp_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t out_byte;
  role_t role;
  logic  starts_extension;
  logic  starts_parameter;
  logic  done_res;
  logic  valid_res;

  modport source (output valid, output out_byte, output role, output starts_extension,
                  output starts_parameter, output done_res, output valid_res, input ready);
  modport sink (input valid, input out_byte, input role, input starts_extension,
                input starts_parameter, input done_res, input valid_res, output ready);
endinterface

// File: src/ehp_front.sv
// front end: accepts input transactions and classifies each byte for the queue
// depends on ehp_pkg and ehp_in_if
module ehp_front import ehp_pkg::*; (
  ehp_in_if.sink       in_ch,
  input  logic         queue_full,
  output logic         push,
  output queue_entry_t push_entry
);

  assign in_ch.ready = !queue_full;
  assign push        = in_ch.valid && !queue_full;

  always_comb begin
    push_entry.data     = in_ch.has_byte ? in_ch.in_byte : '0;
    push_entry.cls      = classify(in_ch.in_byte);
    push_entry.has_byte = in_ch.has_byte;
    push_entry.last     = in_ch.last;
  end

endmodule

// File: src/ehp_queue.sv
// short register queue between the classifier and the grammar engine
// depends on ehp_pkg
module ehp_queue import ehp_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  queue_entry_t push_entry,
  input  logic         pop,
  output logic         full,
  output logic         not_empty,
  output queue_entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  queue_entry_t     slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign head      = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: src/ehp_back.sv
// back end: grammar state machine over classified bytes, with the result register
// depends on ehp_pkg and ehp_out_if
module ehp_back import ehp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         entry_valid,
  input  queue_entry_t entry,
  output logic         pop,
  ehp_out_if.source    out_ch
);

  typedef enum logic [3:0] {
    ST_EXT_PRE,
    ST_EXT_NAME,
    ST_AFTER_ITEM,
    ST_PAR_PRE,
    ST_PAR_NAME,
    ST_AFTER_PNAME,
    ST_VAL_PRE,
    ST_VAL_TOKEN,
    ST_QUOTED,
    ST_ESCAPE,
    ST_ERROR
  } state_t;

  state_t state_r, state_nxt, step_state;
  logic   qne_r, qne_nxt;
  logic   out_valid_r;
  byte_t  out_byte_r;
  role_t  role_r, role_nxt;
  logic   sx_r, sx_nxt;
  logic   sp_r, sp_nxt;
  logic   done_r;
  logic   ok_r, ok_nxt;
  logic   is_sep;
  state_t sep_state;

  assign pop = entry_valid && (!out_valid_r || out_ch.ready);

  assign out_ch.valid            = out_valid_r;
  assign out_ch.out_byte         = out_byte_r;
  assign out_ch.role             = role_r;
  assign out_ch.starts_extension = sx_r;
  assign out_ch.starts_parameter = sp_r;
  assign out_ch.done_res         = done_r;
  assign out_ch.valid_res        = ok_r;

  // comma opens a new extension, semicolon a new parameter
  assign is_sep    = (entry.cls == CLS_COMMA) || (entry.cls == CLS_SEMI);
  assign sep_state = (entry.cls == CLS_SEMI) ? ST_PAR_PRE : ST_EXT_PRE;

  always_comb begin
    step_state = ST_ERROR;
    role_nxt   = ROLE_IGNORE;
    sx_nxt     = 1'b0;
    sp_nxt     = 1'b0;
    qne_nxt    = qne_r;
    if (entry.has_byte) begin
      case (state_r)
        ST_EXT_PRE: begin
          if (entry.cls == CLS_OWS) begin
            step_state = ST_EXT_PRE; role_nxt = ROLE_DELIM;
          end else if (entry.cls == CLS_TOKEN) begin
            step_state = ST_EXT_NAME; role_nxt = ROLE_EXT; sx_nxt = 1'b1;
          end
        end
        ST_EXT_NAME: begin
          if (entry.cls == CLS_TOKEN) begin
            step_state = ST_EXT_NAME; role_nxt = ROLE_EXT;
          end else if (entry.cls == CLS_OWS) begin
            step_state = ST_AFTER_ITEM; role_nxt = ROLE_DELIM;
          end else if (is_sep) begin
            step_state = sep_state; role_nxt = ROLE_DELIM;
          end
        end
        ST_AFTER_ITEM: begin
          if (entry.cls == CLS_OWS) begin
            step_state = ST_AFTER_ITEM; role_nxt = ROLE_DELIM;
          end else if (is_sep) begin
            step_state = sep_state; role_nxt = ROLE_DELIM;
          end
        end
        ST_PAR_PRE: begin
          if (entry.cls == CLS_OWS) begin
            step_state = ST_PAR_PRE; role_nxt = ROLE_DELIM;
          end else if (entry.cls == CLS_TOKEN) begin
            step_state = ST_PAR_NAME; role_nxt = ROLE_PNAME; sp_nxt = 1'b1;
          end
        end
        ST_PAR_NAME: begin
          if (entry.cls == CLS_TOKEN) begin
            step_state = ST_PAR_NAME; role_nxt = ROLE_PNAME;
          end else if (entry.cls == CLS_OWS) begin
            step_state = ST_AFTER_PNAME; role_nxt = ROLE_DELIM;
          end else if (entry.cls == CLS_EQUAL) begin
            step_state = ST_VAL_PRE; role_nxt = ROLE_DELIM;
          end else if (is_sep) begin
            step_state = sep_state; role_nxt = ROLE_DELIM;
          end
        end
        ST_AFTER_PNAME: begin
          if (entry.cls == CLS_OWS) begin
            step_state = ST_AFTER_PNAME; role_nxt = ROLE_DELIM;
          end else if (entry.cls == CLS_EQUAL) begin
            step_state = ST_VAL_PRE; role_nxt = ROLE_DELIM;
          end else if (is_sep) begin
            step_state = sep_state; role_nxt = ROLE_DELIM;
          end
        end
        ST_VAL_PRE: begin
          if (entry.cls == CLS_OWS) begin
            step_state = ST_VAL_PRE; role_nxt = ROLE_DELIM;
          end else if (entry.cls == CLS_QUOTE) begin
            step_state = ST_QUOTED; role_nxt = ROLE_PVALUE; qne_nxt = 1'b0;
          end else if (entry.cls == CLS_TOKEN) begin
            step_state = ST_VAL_TOKEN; role_nxt = ROLE_PVALUE;
          end
        end
        ST_VAL_TOKEN: begin
          if (entry.cls == CLS_TOKEN) begin
            step_state = ST_VAL_TOKEN; role_nxt = ROLE_PVALUE;
          end else if (entry.cls == CLS_OWS) begin
            step_state = ST_AFTER_ITEM; role_nxt = ROLE_DELIM;
          end else if (is_sep) begin
            step_state = sep_state; role_nxt = ROLE_DELIM;
          end
        end
        ST_QUOTED: begin
          // closing quote only counts once the string holds something
          if (entry.cls == CLS_QUOTE) begin
            if (qne_r) begin
              step_state = ST_AFTER_ITEM; role_nxt = ROLE_PVALUE;
            end
          end else if (entry.cls == CLS_BSLASH) begin
            step_state = ST_ESCAPE; role_nxt = ROLE_PVALUE;
          end else if (entry.cls == CLS_TOKEN) begin
            step_state = ST_QUOTED; role_nxt = ROLE_PVALUE; qne_nxt = 1'b1;
          end
        end
        ST_ESCAPE: begin
          if (entry.cls == CLS_TOKEN) begin
            step_state = ST_QUOTED; role_nxt = ROLE_PVALUE; qne_nxt = 1'b1;
          end
        end
        default: begin
          step_state = ST_ERROR;
        end
      endcase
      if (step_state == ST_ERROR) begin
        role_nxt = ROLE_IGNORE;
        sx_nxt   = 1'b0;
        sp_nxt   = 1'b0;
      end
    end else begin
      step_state = state_r;
    end

    ok_nxt = entry.last && ((step_state == ST_EXT_NAME) || (step_state == ST_AFTER_ITEM) ||
                            (step_state == ST_PAR_NAME) || (step_state == ST_AFTER_PNAME) ||
                            (step_state == ST_VAL_TOKEN));

    state_nxt = step_state;
    // end mark returns the parser to its start
    if (entry.last) begin
      state_nxt = ST_EXT_PRE;
      qne_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EXT_PRE;
      qne_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        state_r     <= state_nxt;
        qne_r       <= qne_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte_r <= entry.data;
      role_r     <= role_nxt;
      sx_r       <= sx_nxt;
      sp_r       <= sp_nxt;
      done_r     <= entry.last;
      ok_r       <= ok_nxt;
    end
  end

endmodule

// File: src/extension_header_parser_top.sv
// an accepted input transaction is written into the queue, then the grammar state machine
// pops it and registers the result transaction on the output channel
// throughput: one byte per cycle while the result channel does not stall, set by the grammar
// state machine; the queue between classifier and state machine lets either side stall alone
// reset: synchronous active-low rst_n empties the queue, drops the pending result
// and returns the parser to expecting an extension name
module extension_header_parser_top import ehp_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  ehp_in_if.sink     in_ch,
  ehp_out_if.source  out_ch
);

  logic         push;
  logic         pop;
  logic         queue_full;
  logic         queue_not_empty;
  queue_entry_t push_entry;
  queue_entry_t head;

  ehp_front u_front (
    .in_ch      (in_ch),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  ehp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .not_empty  (queue_not_empty),
    .head       (head)
  );

  ehp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry_valid (queue_not_empty),
    .entry       (head),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule
